/* rtl/core/xdkc_pkg.sv */
// Package for the dual xorshift128+ keystream cipher.
// Holds the seed constants, shift amounts, register indexes, queue types and the
// generator step function. It has no dependencies.
package xdkc_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [WordW-1:0] C_W0 = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WordW-1:0] C_W1 = 64'hbf58_476d_1ce4_e5b9;

    localparam int unsigned ShiftA = 23;
    localparam int unsigned ShiftB = 18;
    localparam int unsigned ShiftC = 5;

    localparam logic [CfgIdxW-1:0] REG_SEED_A_LO = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SEED_A_HI = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_SEED_B_LO = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SEED_B_HI = 2'd3;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             som;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    // Word one of the generator after one step; word zero simply takes old word one.
    function automatic logic [WordW-1:0] xs_next_w1(input logic [WordW-1:0] w0,
                                                    input logic [WordW-1:0] w1);
        logic [WordW-1:0] t;
        t = w0 ^ (w0 << ShiftA);
        return t ^ w1 ^ (t >> ShiftB) ^ (w1 >> ShiftC);
    endfunction

endpackage

/* rtl/core/xdkc_front.sv */
// Front end of the cipher: accepts input beats and holds them in a short queue.
// Depends on xdkc_pkg for the item and queue head types.
module xdkc_front #(
    parameter int unsigned QueueDepth = xdkc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [xdkc_pkg::ByteW-1:0] i_data_in,
    input  logic                     i_start_of_message,
    input  logic                     i_pop,
    output xdkc_pkg::t_q_head        o_head
);

    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    xdkc_pkg::t_item r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            push;
    logic            pop;

    assign o_in_stall = (r_count == CntW'(QueueDepth));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data: i_data_in, som: i_start_of_message};
        end
    end

endmodule

/* rtl/core/xdkc_gen.sv */
// One xorshift128+ generator with reload from a seed pair.
// Depends on xdkc_pkg for the constants and the step function.
module xdkc_gen (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_load,
    input  logic [xdkc_pkg::WordW-1:0] i_seed_lo,
    input  logic [xdkc_pkg::WordW-1:0] i_seed_hi,
    output logic [xdkc_pkg::ByteW-1:0] o_key
);

    logic [xdkc_pkg::WordW-1:0] r_w0, r_w1;
    logic [xdkc_pkg::WordW-1:0] w0_eff, w1_eff;

    // A reload takes effect for the very byte that carries it.
    assign w0_eff = i_load ? (i_seed_lo ^ xdkc_pkg::C_W0) : r_w0;
    assign w1_eff = i_load ? (i_seed_hi ^ xdkc_pkg::C_W1) : r_w1;

    // Only the low byte of the 64-bit sum is ever used.
    assign o_key = w0_eff[xdkc_pkg::ByteW-1:0] + w1_eff[xdkc_pkg::ByteW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= xdkc_pkg::C_W0;
            r_w1 <= xdkc_pkg::C_W1;
        end else if (i_step) begin
            r_w0 <= w1_eff;
            r_w1 <= xdkc_pkg::xs_next_w1(w0_eff, w1_eff);
        end
    end

endmodule

/* rtl/core/xdkc_back.sv */
// Back end of the cipher: takes queued beats, runs both generators and holds the result.
// Depends on xdkc_pkg and xdkc_gen.
module xdkc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  xdkc_pkg::t_q_head          i_head,
    output logic                       o_pop,
    input  logic [xdkc_pkg::WordW-1:0] i_seed_a_lo,
    input  logic [xdkc_pkg::WordW-1:0] i_seed_a_hi,
    input  logic [xdkc_pkg::WordW-1:0] i_seed_b_lo,
    input  logic [xdkc_pkg::WordW-1:0] i_seed_b_hi,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [xdkc_pkg::ByteW-1:0] o_data_out
);

    logic                       r_out_valid;
    logic [xdkc_pkg::ByteW-1:0] r_out_data;
    logic [xdkc_pkg::ByteW-1:0] key_a, key_b;

    // The output register frees up in the same cycle its beat is taken.
    assign o_pop = i_head.valid && (!r_out_valid || !i_out_stall);

    xdkc_gen u_gen_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (o_pop),
        .i_load    (i_head.item.som),
        .i_seed_lo (i_seed_a_lo),
        .i_seed_hi (i_seed_a_hi),
        .o_key     (key_a)
    );

    xdkc_gen u_gen_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (o_pop),
        .i_load    (i_head.item.som),
        .i_seed_lo (i_seed_b_lo),
        .i_seed_hi (i_seed_b_hi),
        .o_key     (key_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= i_head.item.data ^ key_a ^ key_b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;

endmodule

/* rtl/core/xorshift_dual_keystream_cipher_unit.sv */
// Dual xorshift128+ keystream cipher, top level.
// A beat accepted at the input is written into the queue, then into the output register.
// Throughput: one byte per cycle while the output is not stalled and the queue holds a beat.
// The input queue of QueueDepth entries lets input keep flowing while a result is stalled.
// Reset is synchronous, active low: seeds clear to zero, generators load the two constants.
module xorshift_dual_keystream_cipher_unit #(
    parameter int unsigned QueueDepth = xdkc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [xdkc_pkg::ByteW-1:0]   i_data_in,
    input  logic                         i_start_of_message,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [xdkc_pkg::ByteW-1:0]   o_data_out,
    input  logic                         i_cfg_we,
    input  logic [xdkc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [xdkc_pkg::WordW-1:0]   i_cfg_data
);

    logic [xdkc_pkg::WordW-1:0] r_seed_a_lo, r_seed_a_hi, r_seed_b_lo, r_seed_b_hi;
    xdkc_pkg::t_q_head          head;
    logic                       pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_a_lo <= '0;
            r_seed_a_hi <= '0;
            r_seed_b_lo <= '0;
            r_seed_b_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                xdkc_pkg::REG_SEED_A_LO: r_seed_a_lo <= i_cfg_data;
                xdkc_pkg::REG_SEED_A_HI: r_seed_a_hi <= i_cfg_data;
                xdkc_pkg::REG_SEED_B_LO: r_seed_b_lo <= i_cfg_data;
                xdkc_pkg::REG_SEED_B_HI: r_seed_b_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    xdkc_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_in          (i_data_in),
        .i_start_of_message (i_start_of_message),
        .i_pop              (pop),
        .o_head             (head)
    );

    xdkc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_seed_a_lo (r_seed_a_lo),
        .i_seed_a_hi (r_seed_a_hi),
        .i_seed_b_lo (r_seed_b_lo),
        .i_seed_b_hi (r_seed_b_hi),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out)
    );

endmodule

/* rtl/core/xdkc_checker.sv */
// Port-level checker for the cipher top level, attached by the bind below.
// Depends on xdkc_pkg for field widths and the default queue depth.
module xdkc_checker #(
    parameter int unsigned QueueDepth = xdkc_pkg::QUEUE_DEPTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [xdkc_pkg::ByteW-1:0] o_data_out
);

    localparam int unsigned FlightW = $clog2(QueueDepth + 2) + 1;

    logic               in_acc, out_acc;
    logic [FlightW-1:0] r_flight;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Beats accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flight <= '0;
        end else if (in_acc && !out_acc) begin
            r_flight <= r_flight + 1'b1;
        end else if (out_acc && !in_acc) begin
            r_flight <= r_flight - 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_out))
        else $error("stalled output beat changed");

    a_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flight <= FlightW'(QueueDepth + 1)) && (!o_out_valid || r_flight != '0))
        else $error("beat count in flight out of range");

    a_empty_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_flight == '0 |-> ##2 o_out_valid)
        else $error("beat into an empty unit did not appear after two cycles");

endmodule

bind xorshift_dual_keystream_cipher_unit xdkc_checker #(
    .QueueDepth (QueueDepth)
) u_xdkc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_data_out  (o_data_out)
);

/* dv/xorshift_dual_keystream_cipher_unit_test.sv */
// Self-checking testbench for the dual xorshift128+ keystream cipher unit.
// It predicts every output byte from its own model of both generators and the seed registers.
// It depends on xdkc_pkg and on the xorshift_dual_keystream_cipher_unit RTL.
`timescale 1ns / 1ps

module xorshift_dual_keystream_cipher_unit_test;

    typedef struct packed {
        logic [xdkc_pkg::WordW-1:0] lo;
        logic [xdkc_pkg::WordW-1:0] hi;
    } t_xs_state;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [xdkc_pkg::ByteW-1:0]   i_data_in;
    logic                         i_start_of_message;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [xdkc_pkg::ByteW-1:0]   o_data_out;
    logic                         i_cfg_we;
    logic [xdkc_pkg::CfgIdxW-1:0] i_cfg_index;
    logic [xdkc_pkg::WordW-1:0]   i_cfg_data;

    logic [xdkc_pkg::WordW-1:0] seed_key [4];
    t_xs_state                  gen_a;
    t_xs_state                  gen_b;
    logic [xdkc_pkg::ByteW-1:0] expected_bytes [$];

    int   tx_gap_max = 0;
    int   rx_gap_max = 0;
    logic rx_hold = 1'b0;
    int   rx_wait = 0;
    int   error_count = 0;

    xorshift_dual_keystream_cipher_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_in          (i_data_in),
        .i_start_of_message (i_start_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_data_out         (o_data_out),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_xs_state xs_advance(input t_xs_state s);
        t_xs_state                  n;
        logic [xdkc_pkg::WordW-1:0] t;
        t    = s.lo ^ (s.lo << xdkc_pkg::ShiftA);
        n.lo = s.hi;
        n.hi = t ^ s.hi ^ (t >> xdkc_pkg::ShiftB) ^ (s.hi >> xdkc_pkg::ShiftC);
        return n;
    endfunction

    function automatic logic [xdkc_pkg::ByteW-1:0] xs_key_byte(input t_xs_state s);
        logic [xdkc_pkg::WordW-1:0] sum;
        sum = s.lo + s.hi;
        return sum[xdkc_pkg::ByteW-1:0];
    endfunction

    task automatic load_generators();
        gen_a.lo = seed_key[xdkc_pkg::REG_SEED_A_LO] ^ xdkc_pkg::C_W0;
        gen_a.hi = seed_key[xdkc_pkg::REG_SEED_A_HI] ^ xdkc_pkg::C_W1;
        gen_b.lo = seed_key[xdkc_pkg::REG_SEED_B_LO] ^ xdkc_pkg::C_W0;
        gen_b.hi = seed_key[xdkc_pkg::REG_SEED_B_HI] ^ xdkc_pkg::C_W1;
    endtask

    // Works out the cipher byte of one accepted beat and advances both generators.
    task automatic queue_cipher_byte(input logic [xdkc_pkg::ByteW-1:0] data, input logic som);
        logic [xdkc_pkg::ByteW-1:0] key_a;
        logic [xdkc_pkg::ByteW-1:0] key_b;
        if (som) begin
            load_generators();
        end
        key_a = xs_key_byte(gen_a);
        key_b = xs_key_byte(gen_b);
        gen_a = xs_advance(gen_a);
        gen_b = xs_advance(gen_b);
        expected_bytes = {expected_bytes, data ^ key_a ^ key_b};
    endtask

    task automatic send_byte(input logic [xdkc_pkg::ByteW-1:0] data, input logic som);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_data_in          <= data;
        i_start_of_message <= som;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        queue_cipher_byte(data, som);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Seed writes happen only while the block is idle.
    task automatic write_seed(input logic [xdkc_pkg::CfgIdxW-1:0] index,
                              input logic [xdkc_pkg::WordW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seed_key[index] = value;
        @(posedge i_clk);
    endtask

    task automatic write_all_seeds(input logic [xdkc_pkg::WordW-1:0] a_lo,
                                   input logic [xdkc_pkg::WordW-1:0] a_hi,
                                   input logic [xdkc_pkg::WordW-1:0] b_lo,
                                   input logic [xdkc_pkg::WordW-1:0] b_hi);
        write_seed(xdkc_pkg::REG_SEED_A_LO, a_lo);
        write_seed(xdkc_pkg::REG_SEED_A_HI, a_hi);
        write_seed(xdkc_pkg::REG_SEED_B_LO, b_lo);
        write_seed(xdkc_pkg::REG_SEED_B_HI, b_hi);
    endtask

    function automatic logic [xdkc_pkg::WordW-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // Holds the receiver off in a process of its own; the argument sets how long.
    task automatic hold_receiver(input int cycles);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (cycles) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
    endtask

    // Each accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                $error("data_out: unexpected beat, actual %02h", o_data_out);
                error_count++;
            end else begin
                if (o_data_out !== expected_bytes[0]) begin
                    $error("data_out: expected %02h, actual %02h", expected_bytes[0], o_data_out);
                    error_count++;
                end
                void'(expected_bytes.pop_front());
            end
            rx_wait = $urandom_range(0, rx_gap_max);
        end
        if (rx_hold) begin
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // The generators come out of reset at the two constants, before any start of message.
    task automatic test_reset_keystream();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        wait_drained();
    endtask

    // Seed writes take effect only at the next start of message.
    task automatic test_seed_registers();
        tx_gap_max = 2;
        rx_gap_max = 2;
        write_all_seeds('1, '1, '1, '1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        wait_drained();
        write_seed(xdkc_pkg::REG_SEED_A_LO, 64'h0123_4567_89ab_cdef);
        send_byte(8'h3c, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'h7e, 1'b1);
        send_byte(8'he7, 1'b0);
        wait_drained();
        write_all_seeds('0, '0, '0, '0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h5a, 1'b0);
        wait_drained();
    endtask

    // A seed pair that cancels both constants leaves that generator stuck at zero.
    task automatic test_zero_generator();
        tx_gap_max = 0;
        rx_gap_max = 0;
        write_all_seeds(xdkc_pkg::C_W0, xdkc_pkg::C_W1, random_word(), random_word());
        send_byte(8'h12, 1'b1);
        send_byte(8'hfe, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        wait_drained();
        write_seed(xdkc_pkg::REG_SEED_B_LO, xdkc_pkg::C_W0);
        write_seed(xdkc_pkg::REG_SEED_B_HI, xdkc_pkg::C_W1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        wait_drained();
    endtask

    // The receiver holds off long enough for the input side to fill and stall.
    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_gap_max = 0;
        hold_receiver(80);
        send_byte($urandom_range(0, 255), 1'b1);
        for (int i = 0; i < 29; i++) begin
            send_byte($urandom_range(0, 255), 1'b0);
        end
        wait_drained();
    endtask

    task automatic pick_seeds();
        case ($urandom_range(0, 9))
            0: write_all_seeds('1, '1, '1, '1);
            1: write_all_seeds('0, '0, '0, '0);
            2: write_all_seeds(xdkc_pkg::C_W0, xdkc_pkg::C_W1, random_word(), random_word());
            3: write_all_seeds(random_word(), random_word(), xdkc_pkg::C_W0, xdkc_pkg::C_W1);
            default: begin
                for (int r = 0; r < 4; r++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        write_seed(xdkc_pkg::CfgIdxW'(r), random_word());
                    end
                end
            end
        endcase
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 4))
            0: begin tx_gap_max = 0;  rx_gap_max = 0;  end
            1: begin tx_gap_max = 16; rx_gap_max = 16; end
            2: begin tx_gap_max = 0;  rx_gap_max = 16; end
            3: begin tx_gap_max = 16; rx_gap_max = 0;  end
            default: begin tx_gap_max = 4; rx_gap_max = 4; end
        endcase
    endtask

    // Phases of messages with random content, fresh seeds and idling between phases.
    task automatic test_random_messages();
        int sent;
        int phase_target;
        int phase_sent;
        int msg_len;
        logic som;
        sent = 0;
        while (sent < 1600) begin
            pick_seeds();
            pick_idling();
            phase_target = $urandom_range(60, 140);
            phase_sent   = 0;
            while (phase_sent < phase_target) begin
                msg_len = $urandom_range(1, 40);
                for (int k = 0; k < msg_len; k++) begin
                    // Most messages open with a start flag; a few carry a stray one inside.
                    if (k == 0) begin
                        som = ($urandom_range(0, 7) != 0);
                    end else begin
                        som = ($urandom_range(0, 49) == 0);
                    end
                    send_byte($urandom_range(0, 255), som);
                    phase_sent++;
                end
            end
            wait_drained();
            sent += phase_sent;
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_data_in          = '0;
        i_start_of_message = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = xdkc_pkg::REG_SEED_A_LO;
        i_cfg_data         = '0;
        for (int r = 0; r < 4; r++) begin
            seed_key[r] = '0;
        end
        load_generators();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_keystream();
        test_seed_registers();
        test_zero_generator();
        test_backpressure();
        test_random_messages();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
